[design/drcw_pkg.sv]
// Package for the DDA ray wall caster: fixed-point constants, register
// indexes, request and configuration types, sequencer states.
// No dependencies.
package drcw_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE = 17'h10000;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic [31:0] DD_CAP = 32'hFFFFFFFF;
  localparam int RAY_W = 34;

  localparam logic [2:0] REG_PLAYER_X    = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y    = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X  = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y  = 3'd3;
  localparam logic [2:0] REG_CAM_PLANE_X = 3'd4;
  localparam logic [2:0] REG_CAM_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_SCREEN_W    = 3'd6;

  localparam logic REQ_WRITE = 1'b0;

  typedef enum logic {
    KIND_WRITE,
    KIND_CAST
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  cx;
    logic [5:0]  cy;
    logic        wall;
    logic [11:0] column;
  } item_t;

  typedef struct packed {
    logic [21:0] player_x;
    logic [21:0] player_y;
    logic [17:0] view_dir_x;
    logic [17:0] view_dir_y;
    logic [17:0] cam_plane_x;
    logic [17:0] cam_plane_y;
    logic [12:0] screen_width;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_CAM,
    ST_MULX,
    ST_MULY,
    ST_RAYY,
    ST_DDX,
    ST_DDXW,
    ST_DDY,
    ST_DDYW,
    ST_SDX,
    ST_SDY,
    ST_WINIT,
    ST_STEP,
    ST_TEST,
    ST_PERP,
    ST_PDIV,
    ST_OUT
  } state_t;

endpackage

[design/drcw_front.sv]
// Front end of the ray caster: accepts requests, drops map writes that
// fall outside the map, and queues the rest for the back end.
// Depends on drcw_pkg.
module drcw_front import drcw_pkg::*; #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        cell_is_wall,
  input  logic [11:0] column,
  input  logic        clearing,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  logic       enq;
  logic       deq;
  item_t      in_item;

  always_comb begin
    in_item.kind   = (req_type == REQ_WRITE) ? KIND_WRITE : KIND_CAST;
    in_item.cx     = cell_x;
    in_item.cy     = cell_y;
    in_item.wall   = cell_is_wall;
    in_item.column = column;
    // drop writes outside the map
    keep = (in_item.kind == KIND_CAST) ||
           ((32'(cell_x) < MAP_WIDTH) && (32'(cell_y) < MAP_HEIGHT));
  end

  assign full    = (count == 2'd2) || clearing;
  assign accept  = push && !full;
  assign enq     = accept && keep;
  assign q_valid = (count != 2'd0);
  assign deq     = q_pop && q_valid;
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) wr_ptr <= !wr_ptr;
      if (deq) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

[design/drcw_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module drcw_div #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dv;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial    = {rem, q[DVD_W-1]};
  assign fits     = trial >= {1'b0, dv};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dv  <= divisor;
    end else if (run) begin
      rem <= fits ? DVS_W'(trial - {1'b0, dv}) : DVS_W'(trial);
      q   <= {q[DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CNT_W'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DVD_W);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) run <= 1'b0;
      end
    end
  end

endmodule

[design/drcw_back.sv]
// Back end of the ray caster: map memory with clearing pass, cast
// sequencer, DDA walk and result register. Depends on drcw_pkg, drcw_div.
module drcw_back import drcw_pkg::*; #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        clearing,
  input  logic        pop,
  output logic        empty,
  output logic [23:0] wall_distance,
  output logic        hit_side,
  output logic [5:0]  hit_x,
  output logic [5:0]  hit_y,
  output logic [1:0]  wall_face,
  output logic        escaped
);

  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
  localparam int CW0   = $clog2(MAXD) + 2;
  localparam int CW    = (CW0 > 8) ? CW0 : 8;
  localparam int LIMIT = MAP_WIDTH + MAP_HEIGHT + 2;
  localparam int NW    = $clog2(LIMIT + 1);
  localparam int SD_W  = RAY_W + NW;
  localparam int NUM_W = (((CW + FRAC_BITS) > 23) ? (CW + FRAC_BITS) : 23) + 1;
  localparam int DVD_W = ((NUM_W + FRAC_BITS) > 33) ? (NUM_W + FRAC_BITS) : 33;

  state_t state, state_next;

  logic mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;
  logic [AW-1:0] clr_cnt;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [RAY_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  logic signed [30:0]      cam;
  logic signed [18:0]      mul_a;
  logic signed [34:0]      mul_b;
  logic signed [53:0]      mul_p;
  logic signed [RAY_W-1:0] rdx, rdy;
  logic [RAY_W-1:0]        abs_x, abs_y;
  logic [31:0]             ddx, ddy;
  logic [16:0]             span_x, span_y;
  logic [SD_W-1:0]         sdx, sdy;
  logic signed [CW-1:0]    mx, my, nx, ny, sx, sy;
  logic [NW-1:0]           n;
  logic                    side, esc, step_x, out_of_map, pneg;
  logic [1:0]              face, last_face, face_calc;
  logic [23:0]             wall_dist;
  logic [12:0]             scr_w;

  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_mag;
  logic signed [RAY_W-1:0] ray_sel;
  logic [RAY_W-1:0]        ray_mag;

  logic res_valid;

  drcw_div #(.DVD_W(DVD_W), .DVS_W(RAY_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // map memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  assign clearing = (state == ST_CLR);
  assign scr_w    = (cfg.screen_width == 13'd0) ? 13'd1 : cfg.screen_width;
  assign abs_x    = rdx[RAY_W-1] ? RAY_W'(-rdx) : RAY_W'(rdx);
  assign abs_y    = rdy[RAY_W-1] ? RAY_W'(-rdy) : RAY_W'(rdy);
  assign span_x   = rdx[RAY_W-1] ? {1'b0, cfg.player_x[15:0]}
                                 : ONE - {1'b0, cfg.player_x[15:0]};
  assign span_y   = rdy[RAY_W-1] ? {1'b0, cfg.player_y[15:0]}
                                 : ONE - {1'b0, cfg.player_y[15:0]};
  assign sx       = rdx[RAY_W-1] ? -CW'(1) : CW'(1);
  assign sy       = rdy[RAY_W-1] ? -CW'(1) : CW'(1);

  // one DDA step
  always_comb begin
    step_x = sdx < sdy;
    nx = step_x ? mx + sx : mx;
    ny = step_x ? my : my + sy;
    out_of_map = nx[CW-1] || ny[CW-1] ||
                 (nx >= $signed(CW'(MAP_WIDTH))) || (ny >= $signed(CW'(MAP_HEIGHT)));
    mem_raddr = AW'(32'(ny[CW-1:0]) * MAP_WIDTH + 32'(nx[CW-1:0]));
  end

  // perpendicular distance numerator on the side that was crossed
  always_comb begin
    logic signed [NUM_W-1:0] cell_s;
    logic signed [NUM_W-1:0] pos_s;
    logic                    neg;
    if (side) begin
      cell_s = NUM_W'(my);
      pos_s  = $signed(NUM_W'(cfg.player_y));
      neg    = rdy[RAY_W-1];
      ray_sel = rdy;
      ray_mag = abs_y;
    end else begin
      cell_s = NUM_W'(mx);
      pos_s  = $signed(NUM_W'(cfg.player_x));
      neg    = rdx[RAY_W-1];
      ray_sel = rdx;
      ray_mag = abs_x;
    end
    num = (cell_s <<< FRAC_BITS) - pos_s + (neg ? $signed(NUM_W'(ONE)) : '0);
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  end

  always_comb begin
    face_calc = last_face;
    if (rdx > 0 && rdy > 0)       face_calc = side ? 2'd1 : 2'd2;
    else if (!rdx[RAY_W-1] && rdy[RAY_W-1]) face_calc = side ? 2'd0 : 2'd2;
    else if (rdx[RAY_W-1] && rdy[RAY_W-1])  face_calc = side ? 2'd0 : 2'd3;
    else if (rdx[RAY_W-1] && rdy > 0)       face_calc = side ? 2'd1 : 2'd3;
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      ST_MULX: begin
        mul_a = {cfg.cam_plane_x[17], cfg.cam_plane_x};
        mul_b = 35'(cam);
      end
      ST_MULY: begin
        mul_a = {cfg.cam_plane_y[17], cfg.cam_plane_y};
        mul_b = 35'(cam);
      end
      ST_SDX: begin
        mul_a = $signed({2'b0, span_x});
        mul_b = $signed({3'b0, ddx});
      end
      ST_SDY: begin
        mul_a = $signed({2'b0, span_y});
        mul_b = $signed({3'b0, ddy});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLR;
    else     state <= state_next;
  end

  // next state, memory write port and divider launch
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = AW'(32'(q_item.cy) * MAP_WIDTH + 32'(q_item.cx));
    mem_wdata  = q_item.wall;
    div_start  = 1'b0;
    div_dvd    = DVD_W'({q_item.column, 17'b0});
    div_dvs    = RAY_W'(scr_w);
    case (state)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = 1'b0;
        if (clr_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == KIND_WRITE) begin
            mem_we = 1'b1;
          end else begin
            div_start  = 1'b1;
            state_next = ST_CAM;
          end
        end
      end
      ST_CAM:   if (div_done) state_next = ST_MULX;
      ST_MULX:  state_next = ST_MULY;
      ST_MULY:  state_next = ST_RAYY;
      ST_RAYY:  state_next = ST_DDX;
      ST_DDX: begin
        div_dvd = DVD_W'(33'h1_0000_0000);
        div_dvs = abs_x;
        if (rdy == 0 || rdx == 0) begin
          state_next = ST_DDY;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DDXW;
        end
      end
      ST_DDXW:  if (div_done) state_next = ST_DDY;
      ST_DDY: begin
        div_dvd = DVD_W'(33'h1_0000_0000);
        div_dvs = abs_y;
        if (rdx == 0 || rdy == 0) begin
          state_next = ST_SDX;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DDYW;
        end
      end
      ST_DDYW:  if (div_done) state_next = ST_SDX;
      ST_SDX:   state_next = ST_SDY;
      ST_SDY:   state_next = ST_WINIT;
      ST_WINIT: state_next = ST_STEP;
      ST_STEP:  state_next = out_of_map ? ST_OUT : ST_TEST;
      ST_TEST: begin
        if (mem_rdata)                state_next = ST_PERP;
        else if (n == NW'(LIMIT))     state_next = ST_OUT;
        else                          state_next = ST_STEP;
      end
      ST_PERP: begin
        div_dvd = DVD_W'({num_mag, 16'b0});
        div_dvs = ray_mag;
        if (ray_sel == 0) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_PDIV;
        end
      end
      ST_PDIV:  if (div_done) state_next = ST_OUT;
      ST_OUT:   if (!res_valid || pop) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // cast datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        esc <= 1'b0;
      end
      ST_CAM: begin
        cam <= $signed(div_q[30:0]) - $signed(31'(ONE));
      end
      ST_MULY: begin
        rdx <= $signed(RAY_W'(signed'(cfg.view_dir_x))) + $signed(mul_p[49:16]);
      end
      ST_RAYY: begin
        rdy <= $signed(RAY_W'(signed'(cfg.view_dir_y))) + $signed(mul_p[49:16]);
      end
      ST_DDX: begin
        if (rdy == 0)      ddx <= 32'd0;
        else if (rdx == 0) ddx <= 32'(ONE);
      end
      ST_DDXW: begin
        if (div_done) ddx <= (div_q > DVD_W'(DD_CAP)) ? DD_CAP : div_q[31:0];
      end
      ST_DDY: begin
        if (rdx == 0)      ddy <= 32'd0;
        else if (rdy == 0) ddy <= 32'(ONE);
      end
      ST_DDYW: begin
        if (div_done) ddy <= (div_q > DVD_W'(DD_CAP)) ? DD_CAP : div_q[31:0];
      end
      ST_SDY: begin
        sdx <= SD_W'(mul_p[49:16]);
      end
      ST_WINIT: begin
        sdy  <= SD_W'(mul_p[49:16]);
        mx   <= CW'(cfg.player_x[21:16]);
        my   <= CW'(cfg.player_y[21:16]);
        n    <= '0;
        side <= 1'b0;
      end
      ST_STEP: begin
        if (step_x) sdx <= sdx + SD_W'(ddx);
        else        sdy <= sdy + SD_W'(ddy);
        mx   <= nx;
        my   <= ny;
        side <= !step_x;
        n    <= n + NW'(1);
        if (out_of_map) esc <= 1'b1;
      end
      ST_TEST: begin
        if (!mem_rdata && n == NW'(LIMIT)) esc <= 1'b1;
      end
      ST_PERP: begin
        face      <= face_calc;
        pneg      <= num[NUM_W-1] ^ ray_sel[RAY_W-1];
        wall_dist <= DIST_MAX;
      end
      ST_PDIV: begin
        if (div_done) begin
          if (pneg)                          wall_dist <= 24'd0;
          else if (div_q > DVD_W'(DIST_MAX)) wall_dist <= DIST_MAX;
          else                               wall_dist <= div_q[23:0];
        end
      end
      default: begin
      end
    endcase
  end

  // clear counter, result register, stored face
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      res_valid <= 1'b0;
      last_face <= 2'd0;
    end else begin
      if (state == ST_CLR) clr_cnt <= clr_cnt + AW'(1);
      if (pop && res_valid) res_valid <= 1'b0;
      if (state == ST_OUT && (!res_valid || pop)) begin
        res_valid <= 1'b1;
        if (!esc) last_face <= face;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!res_valid || pop)) begin
      hit_side <= side;
      escaped  <= esc;
      if (esc) begin
        wall_distance <= DIST_MAX;
        hit_x         <= 6'd0;
        hit_y         <= 6'd0;
        wall_face     <= last_face;
      end else begin
        wall_distance <= wall_dist;
        hit_x         <= mx[5:0];
        hit_y         <= my[5:0];
        wall_face     <= face;
      end
    end
  end

  assign empty = !res_valid;

`ifndef SYNTHESIS
  a_esc_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && escaped) |-> (wall_distance == DIST_MAX && hit_x == 6'd0 && hit_y == 6'd0))
    else $error("escaped result carries hit fields");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST) |-> (n != '0 && n <= NW'(LIMIT)))
    else $error("walk step count out of range");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_CAM || state == ST_DDXW || state == ST_DDYW || state == ST_PDIV))
    else $error("divider finished with no waiting stage");
  a_no_pop_clr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR) |-> !q_pop)
    else $error("request taken during map clear");
`endif

endmodule

[design/dda_ray_wall_cast_core.sv]
// Cast: one divide for the camera offset, up to two delta divides and one
// distance divide, each of 41 quotient bits at the default map; each DDA
// step is a step state, then a registered map read. Map writes are done
// from the idle state as they are taken. One request is worked at a time.
// Reset: synchronous; the 4096-entry map is cleared by a pass over every
// entry, during which full is held high.
module dda_ray_wall_cast_core import drcw_pkg::*; #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request queue side
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        cell_is_wall,
  input  logic [11:0] column,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [23:0] wall_distance,
  output logic        hit_side,
  output logic [5:0]  hit_x,
  output logic [5:0]  hit_y,
  output logic [1:0]  wall_face,
  output logic        escaped,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic       clearing;
  logic       q_valid;
  logic       q_pop;
  item_t      q_item;

  // configuration registers, written at the access phase of a request
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.player_x     <= 22'd2097152;
      cfg.player_y     <= 22'd2097152;
      cfg.view_dir_x   <= 18'h30000;
      cfg.view_dir_y   <= 18'd0;
      cfg.cam_plane_x  <= 18'd0;
      cfg.cam_plane_y  <= 18'd43253;
      cfg.screen_width <= 13'd640;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PLAYER_X:    cfg.player_x     <= pwdata[21:0];
        REG_PLAYER_Y:    cfg.player_y     <= pwdata[21:0];
        REG_VIEW_DIR_X:  cfg.view_dir_x   <= pwdata[17:0];
        REG_VIEW_DIR_Y:  cfg.view_dir_y   <= pwdata[17:0];
        REG_CAM_PLANE_X: cfg.cam_plane_x  <= pwdata[17:0];
        REG_CAM_PLANE_Y: cfg.cam_plane_y  <= pwdata[17:0];
        REG_SCREEN_W:    cfg.screen_width <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  // readback: raw register bits, zero extended
  always_comb begin
    case (cfg_idx)
      REG_PLAYER_X:    prdata = {10'd0, cfg.player_x};
      REG_PLAYER_Y:    prdata = {10'd0, cfg.player_y};
      REG_VIEW_DIR_X:  prdata = {14'd0, cfg.view_dir_x};
      REG_VIEW_DIR_Y:  prdata = {14'd0, cfg.view_dir_y};
      REG_CAM_PLANE_X: prdata = {14'd0, cfg.cam_plane_x};
      REG_CAM_PLANE_Y: prdata = {14'd0, cfg.cam_plane_y};
      REG_SCREEN_W:    prdata = {19'd0, cfg.screen_width};
      default:         prdata = 32'd0;
    endcase
  end

  // front: take requests, drop off-map writes, queue the rest
  drcw_front #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_is_wall (cell_is_wall),
    .column       (column),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // back: map store, cast sequencer and result register
  drcw_back #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .pop           (pop),
    .empty         (empty),
    .wall_distance (wall_distance),
    .hit_side      (hit_side),
    .hit_x         (hit_x),
    .hit_y         (hit_y),
    .wall_face     (wall_face),
    .escaped       (escaped)
  );

endmodule
